[rtl/integer_to_radix_ascii_macros.svh]
// Assertion macros shared by the integer-to-ASCII converter RTL.
// Pulled in by `include from the modules that carry assertions; depends on nothing.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/itoa_pkg.sv]
// Constants and helper functions for the integer-to-ASCII converter.
// Self-contained; imported by integer_to_radix_ascii.
`default_nettype none

package itoa_pkg;

    // Default word width of the converted integer.
    localparam int WORD_WIDTH_DEF = 32;

    // Radix limits and reset value.
    localparam int BASE_W = 6;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_MINUS    = 8'h2D;
    localparam logic [7:0] LETTER_OFFSET = 8'd7;
    localparam logic [BASE_W-1:0] DIGIT_MAX_DEC = 6'd9;

    // Clamp the stored radix into the legal range 2..36.
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] raw);
        logic [BASE_W-1:0] b;
        b = raw;
        if (raw inside {[6'd0:6'd1]})
        begin
            b = BASE_MIN;
        end
        else if (raw inside {[6'd37:6'd63]})
        begin
            b = BASE_MAX;
        end
        return b;
    endfunction

    // Map a digit value 0..35 to '0'..'9' or 'A'..'Z'.
    function automatic logic [7:0] digit_char(input logic [BASE_W-1:0] d);
        logic [7:0] c;
        c = {2'b00, d} + CHAR_ZERO;
        if (d > DIGIT_MAX_DEC)
        begin
            c = c + LETTER_OFFSET;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/integer_to_radix_ascii.sv]
// Signed integer to ASCII text in a configurable radix, digit-serial datapath.
// Depends on itoa_pkg and integer_to_radix_ascii_macros.svh.
//
//  Channel   | Handshake                 | Payload
//  ----------+---------------------------+-----------------------------
//  command   | start / busy              | number_in
//  config    | cfg_valid / cfg_ready     | cfg_data (radix)
//  result    | char_valid (strobe)       | text_char, final_char
//
// Each digit comes from a bit-serial restoring division of the magnitude by the
// radix: the quotient bit sweep runs in ST_DIV, then ST_DIGIT pushes the digit.
// Once every digit is on the stack, characters follow at one per cycle, with a minus
// sign first for a negative number. The shared divider loop produces the digits
// one at a time, and a new command is not taken until the last character is out.
// Reset clears the control state and sets the radix to 10. Results are strobed for
// one cycle each and cannot be stalled; busy stays high until the last is issued.
`default_nettype none
`include "integer_to_radix_ascii_macros.svh"

module integer_to_radix_ascii
    import itoa_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Command channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [WORD_WIDTH-1:0] number_in,
    // Configuration channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [BASE_W-1:0]     cfg_data,
    // Result channel
    output logic                       char_valid,
    output logic [7:0]                 text_char,
    output logic                       final_char
);

    localparam int BIT_W = $clog2(WORD_WIDTH);
    localparam int CNT_W = $clog2(WORD_WIDTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_DIGIT = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic                  neg_reg, neg_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  char_valid_reg, char_valid_next;
    logic [WORD_WIDTH-1:0] mag_reg, mag_next;
    logic [BASE_W-1:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]     stack_reg [WORD_WIDTH];
    logic [BASE_W-1:0]     stack_next [WORD_WIDTH];
    logic [7:0]            text_char_reg, text_char_next;
    logic                  final_char_reg, final_char_next;

    logic [BASE_W-1:0]     eff_base;
    logic [BASE_W:0]       trial;
    logic [BASE_W:0]       diff;
    logic                  ge;
    logic                  accept;

    assign eff_base  = clamp_base(base_reg);
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    // One restoring division step: shift in the next dividend bit and trial-subtract.
    assign trial = {rem_reg, mag_reg[WORD_WIDTH-1]};
    assign diff  = trial - {1'b0, eff_base};
    assign ge    = (trial >= {1'b0, eff_base});

    // Next-state and datapath logic.
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        neg_next        = neg_reg;
        bit_cnt_next    = bit_cnt_reg;
        count_next      = count_reg;
        mag_next        = mag_reg;
        rem_next        = rem_reg;
        stack_next      = stack_reg;
        char_valid_next = 1'b0;
        text_char_next  = text_char_reg;
        final_char_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            base_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next     = number_in[WORD_WIDTH-1];
                    mag_next     = number_in[WORD_WIDTH-1] ? (~number_in + 1'b1) : number_in;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    count_next   = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mag_next = {mag_reg[WORD_WIDTH-2:0], ge};
                rem_next = ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
                if (bit_cnt_reg == BIT_W'(WORD_WIDTH - 1))
                begin
                    state_next = ST_DIGIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_DIGIT:
            begin
                // Push the remainder onto the digit stack, least significant first.
                stack_next[0] = rem_reg;
                for (int i = 1; i < WORD_WIDTH; i++)
                begin
                    stack_next[i] = stack_reg[i-1];
                end
                count_next   = count_reg + 1'b1;
                rem_next     = '0;
                bit_cnt_next = '0;
                if ((mag_reg == '0) || (count_reg == CNT_W'(WORD_WIDTH - 1)))
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_SIGN:
            begin
                char_valid_next = 1'b1;
                text_char_next  = CHAR_MINUS;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Pop the most significant digit each cycle.
                char_valid_next = 1'b1;
                text_char_next  = digit_char(stack_reg[0]);
                final_char_next = (count_reg == CNT_W'(1));
                for (int i = 0; i < WORD_WIDTH - 1; i++)
                begin
                    stack_next[i] = stack_reg[i+1];
                end
                stack_next[WORD_WIDTH-1] = '0;
                count_next = count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            base_reg       <= BASE_RESET;
            bit_cnt_reg    <= '0;
            count_reg      <= '0;
            char_valid_reg <= 1'b0;
            final_char_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            bit_cnt_reg    <= bit_cnt_next;
            count_reg      <= count_next;
            char_valid_reg <= char_valid_next;
            final_char_reg <= final_char_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        mag_reg       <= mag_next;
        rem_reg       <= rem_next;
        stack_reg     <= stack_next;
        text_char_reg <= text_char_next;
    end

    assign char_valid = char_valid_reg;
    assign text_char  = text_char_reg;
    assign final_char = final_char_reg;

    // Checks on the sequencer and divider.
    `ITOA_ASSERT_SAME(a_rem_below_base, clk, rst_n, (state_reg == ST_DIV), (rem_reg < eff_base), "remainder reached the radix during division")
    `ITOA_ASSERT_SAME(a_count_bounded, clk, rst_n, 1'b1, (count_reg <= CNT_W'(WORD_WIDTH)), "digit count exceeds the word width")
    `ITOA_ASSERT_SAME(a_emit_has_digits, clk, rst_n, (state_reg == ST_EMIT), (count_reg != '0), "emitting with an empty digit stack")
    `ITOA_ASSERT_NEXT(a_strobe_source, clk, rst_n, (state_reg != ST_EMIT) && (state_reg != ST_SIGN), !char_valid_reg, "character strobe outside emission")
    `ITOA_ASSERT_SAME(a_final_with_strobe, clk, rst_n, final_char_reg, char_valid_reg, "final flag without a character beat")

endmodule

`default_nettype wire
